// ----- rtl/mph_pkg.sv -----
// Shared types, constants and helper functions of the masked pixel histogram.
package mph_pkg;

  localparam int BIN_COUNT   = 256;
  localparam int COUNT_WIDTH = 32;
  localparam int BIN_W       = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int OUT_WIDTH   = 32;
  localparam int PIX_WIDTH   = 8;
  localparam int MODE_WIDTH  = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [63:0] OUT_MAX = 64'h0000_0000_FFFF_FFFF;

  // Input item modes.
  localparam logic [MODE_WIDTH-1:0] MODE_ACCUM = 2'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MASK_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_MARKER   = 2'd2;

  localparam logic [PIX_WIDTH-1:0] EDGE_MARKER_RESET = 8'd255;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [BIN_W-1:0]       bin_addr_t;
  typedef logic [OUT_WIDTH-1:0]   out_count_t;
  typedef logic [PIX_WIDTH-1:0]   pix_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_ACCUM,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    logic       mask_enable;
    logic       border_enable;
    pix_t       edge_marker;
  } cfg_t;

  typedef struct packed {
    op_t        op;
    logic       in_range;
    logic       border_inc;
    bin_addr_t  addr;
  } item_ctl_t;

  typedef struct packed {
    logic       en;
    logic       clear;
    bin_addr_t  addr;
    count_t     main_val;
    count_t     border_val;
  } store_wr_t;

  function automatic count_t bump(input count_t c);
    count_t r;
    if (c == '1) begin
      r = c;
    end else begin
      r = c + COUNT_WIDTH'(1);
    end
    return r;
  endfunction

  function automatic out_count_t clip_out(input count_t c);
    out_count_t r;
    if (64'(c) > OUT_MAX) begin
      r = '1;
    end else begin
      r = OUT_WIDTH'(c);
    end
    return r;
  endfunction

endpackage

// ----- rtl/mph_if.sv -----
// Channel interfaces of the masked pixel histogram: pixel input, result output, config write.
interface mph_pix_if;
  logic                                valid;
  logic                                ready;
  logic [mph_pkg::MODE_WIDTH-1:0]      mode;
  logic [mph_pkg::PIX_WIDTH-1:0]       pixel;
  logic [mph_pkg::PIX_WIDTH-1:0]       mask_value;

  modport source (output valid, output mode, output pixel, output mask_value, input ready);
  modport sink   (input valid, input mode, input pixel, input mask_value, output ready);
endinterface

interface mph_res_if;
  logic                                valid;
  logic                                ready;
  logic [mph_pkg::OUT_WIDTH-1:0]       bin_count;
  logic [mph_pkg::OUT_WIDTH-1:0]       border_count;

  modport source (output valid, output bin_count, output border_count, input ready);
  modport sink   (input valid, input bin_count, input border_count, output ready);
endinterface

interface mph_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mph_pkg::CFG_IDX_W-1:0]       index;
  logic [mph_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/mph_cfg_regs.sv -----
// Configuration registers of the masked pixel histogram.
module mph_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  mph_cfg_if.sink       cfg,
  output mph_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.mask_enable   <= 1'b0;
      regs.border_enable <= 1'b0;
      regs.edge_marker   <= mph_pkg::EDGE_MARKER_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        mph_pkg::REG_MASK_ENABLE: begin
          regs.mask_enable <= cfg.data[0];
        end
        mph_pkg::REG_BORDER_ENABLE: begin
          regs.border_enable <= cfg.data[0];
        end
        mph_pkg::REG_EDGE_MARKER: begin
          regs.edge_marker <= mph_pkg::PIX_WIDTH'(cfg.data);
        end
        default: begin
          // Writes to unassigned indexes are dropped.
        end
      endcase
    end
  end

endmodule

// ----- rtl/mph_classify.sv -----
// Decodes one input beat into the operation, bin address and border decision.
module mph_classify (
  input  logic [mph_pkg::MODE_WIDTH-1:0] mode,
  input  mph_pkg::pix_t                  pixel,
  input  mph_pkg::pix_t                  mask_value,
  input  mph_pkg::cfg_t                  regs,
  output mph_pkg::item_ctl_t             ctl
);

  logic in_range;
  logic counts;
  logic is_edge;

  assign in_range = (32'(pixel) < 32'(mph_pkg::BIN_COUNT));

  always_comb begin
    if (regs.mask_enable) begin
      counts  = (mask_value != '0);
      is_edge = (mask_value == regs.edge_marker);
    end else begin
      counts  = 1'b1;
      is_edge = (pixel == regs.edge_marker);
    end
  end

  always_comb begin
    ctl.in_range   = in_range;
    ctl.addr       = mph_pkg::BIN_W'(pixel);
    ctl.border_inc = regs.border_enable && is_edge;
    unique case (mode)
      mph_pkg::MODE_ACCUM: begin
        ctl.op = (in_range && counts) ? mph_pkg::OP_ACCUM : mph_pkg::OP_NONE;
      end
      mph_pkg::MODE_READ: begin
        ctl.op = mph_pkg::OP_READ;
      end
      mph_pkg::MODE_CLEAR: begin
        ctl.op = in_range ? mph_pkg::OP_CLEAR : mph_pkg::OP_NONE;
      end
      default: begin
        ctl.op = mph_pkg::OP_NONE;
      end
    endcase
  end

endmodule

// ----- rtl/mph_bin_store.sv -----
// Main and border bin memories with per-bin valid bits and a registered read port.
module mph_bin_store (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  mph_pkg::bin_addr_t  rd_addr,
  input  mph_pkg::store_wr_t  wr,
  output mph_pkg::count_t     rd_main,
  output mph_pkg::count_t     rd_border,
  output logic                rd_valid
);

  mph_pkg::count_t             main_mem   [mph_pkg::BIN_COUNT];
  mph_pkg::count_t             border_mem [mph_pkg::BIN_COUNT];
  logic [mph_pkg::BIN_COUNT-1:0] valid_bits;

  // A bin whose valid bit is low reads as zero; clearing a bin only drops its bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (wr.en) begin
      valid_bits[wr.addr] <= !wr.clear;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && !wr.clear) begin
      main_mem[wr.addr]   <= wr.main_val;
      border_mem[wr.addr] <= wr.border_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_main   <= main_mem[rd_addr];
      rd_border <= border_mem[rd_addr];
      rd_valid  <= valid_bits[rd_addr];
    end
  end

endmodule

// ----- rtl/masked_pixel_histogram_top.sv -----
// Top level of the masked pixel histogram: pipeline control, bin update and result register.
//
// Usage: pixel beats enter on pix (mode, pixel, mask_value). Accumulate beats add one
// to the pixel's bin of the main histogram, and of the border histogram when the pixel
// is an edge pixel and border counting is on; counters saturate. Clear beats zero one
// bin of both stores. Read beats return one result beat on res with both counts.
// Accumulate, clear and unused-mode beats return nothing. Registers are written on cfg
// (index 0 mask_enable, 1 border_enable, 2 edge_marker); the user must write them only
// while the block is idle, which the block itself does not enforce. Throughput: one beat
// per cycle unless a stalled read holds the update stage. Bins are read as a beat is
// accepted and written back in the following cycle, with the last write forwarded to cover
// back-to-back hits on the same bin. Read results are registered onto res. When res stalls,
// a read beat waits in the update stage and pix.ready drops only once that stage holds a
// read; accumulate and clear beats keep flowing. Reset clears both histograms at once
// through per-bin valid bits, so beats are taken as soon as reset ends.
module masked_pixel_histogram_top (
  input  logic    clk,
  input  logic    rst,
  mph_cfg_if.sink cfg,
  mph_pix_if.sink pix,
  mph_res_if.source res
);

  mph_pkg::cfg_t       regs;
  mph_pkg::item_ctl_t  in_ctl;
  mph_pkg::item_ctl_t  s1_ctl;
  logic                s1_valid;
  logic                s1_go;
  logic                accept;

  mph_pkg::store_wr_t  wr;
  mph_pkg::count_t     rd_main;
  mph_pkg::count_t     rd_border;
  logic                rd_valid;

  logic                last_wr_valid;
  mph_pkg::bin_addr_t  last_wr_addr;
  mph_pkg::count_t     last_wr_main;
  mph_pkg::count_t     last_wr_border;

  logic                fwd_hit;
  mph_pkg::count_t     cur_main;
  mph_pkg::count_t     cur_border;

  mph_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  mph_classify u_classify (
    .mode       (pix.mode),
    .pixel      (pix.pixel),
    .mask_value (pix.mask_value),
    .regs       (regs),
    .ctl        (in_ctl)
  );

  mph_bin_store u_bin_store (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept && in_ctl.in_range),
    .rd_addr   (in_ctl.addr),
    .wr        (wr),
    .rd_main   (rd_main),
    .rd_border (rd_border),
    .rd_valid  (rd_valid)
  );

  assign s1_go = s1_valid && ((s1_ctl.op != mph_pkg::OP_READ) || !res.valid || res.ready);
  assign pix.ready = !s1_valid || s1_go;
  assign accept = pix.valid && pix.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl <= in_ctl;
    end
  end

  // The memory read misses only the write made on the same edge, which is always the
  // most recent write and so is held in the last-write register.
  assign fwd_hit = last_wr_valid && (last_wr_addr == s1_ctl.addr);

  always_comb begin
    if (fwd_hit) begin
      cur_main   = last_wr_main;
      cur_border = last_wr_border;
    end else if (rd_valid) begin
      cur_main   = rd_main;
      cur_border = rd_border;
    end else begin
      cur_main   = '0;
      cur_border = '0;
    end
  end

  always_comb begin
    wr.addr       = s1_ctl.addr;
    wr.clear      = (s1_ctl.op == mph_pkg::OP_CLEAR);
    wr.en         = s1_go && ((s1_ctl.op == mph_pkg::OP_ACCUM) ||
                              (s1_ctl.op == mph_pkg::OP_CLEAR));
    if (wr.clear) begin
      wr.main_val   = '0;
      wr.border_val = '0;
    end else begin
      wr.main_val   = mph_pkg::bump(cur_main);
      wr.border_val = s1_ctl.border_inc ? mph_pkg::bump(cur_border) : cur_border;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_wr_valid <= 1'b0;
    end else if (wr.en) begin
      last_wr_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      last_wr_addr   <= wr.addr;
      last_wr_main   <= wr.main_val;
      last_wr_border <= wr.border_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (s1_go && (s1_ctl.op == mph_pkg::OP_READ)) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && (s1_ctl.op == mph_pkg::OP_READ)) begin
      if (s1_ctl.in_range) begin
        res.bin_count    <= mph_pkg::clip_out(cur_main);
        res.border_count <= mph_pkg::clip_out(cur_border);
      end else begin
        res.bin_count    <= '0;
        res.border_count <= '0;
      end
    end
  end

  // A stalled update stage keeps its item unchanged.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_ctl))
    else $error("update stage lost or changed a stalled item");

  // Only a read item can hold the update stage.
  a_stall_is_read: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |-> (s1_ctl.op == mph_pkg::OP_READ) && res.valid && !res.ready)
    else $error("update stage stalled without a blocked read");

  // Every bin write is captured for forwarding on the next cycle.
  a_fwd_capture: assert property (@(posedge clk) disable iff (rst)
    wr.en |=> last_wr_valid && (last_wr_addr == $past(wr.addr)) &&
              (last_wr_main == $past(wr.main_val)))
    else $error("last write not captured for forwarding");

  // A new result is raised only by a read item leaving the update stage.
  a_res_from_read: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(res.valid) |-> $past(s1_go && (s1_ctl.op == mph_pkg::OP_READ)))
    else $error("result beat without a read item");

endmodule
